// ----- hdl/tcc_pkg.sv -----
package tcc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int LAT_W      = 12;
    localparam int CNT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LAT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT     = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_LOOK,
        S_BINV,
        S_NRD,
        S_NFILL,
        S_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             near_miss;
        logic             far_miss;
        logic [LAT_W-1:0] lat;
    } t_stat_upd;

    typedef struct packed {
        logic [CNT_W-1:0] acc;
        logic [CNT_W-1:0] near_miss;
        logic [CNT_W-1:0] far_acc;
        logic [CNT_W-1:0] far_miss;
        logic [CNT_W-1:0] lat;
    } t_totals;

endpackage

// ----- hdl/tcc_stats.sv -----
module tcc_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcc_pkg::t_stat_upd i_upd,
    output tcc_pkg::t_totals   o_tot
);
    import tcc_pkg::*;

    t_totals r_tot;
    t_totals n_tot;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    always_comb begin
        n_tot = r_tot;
        if (i_upd.valid) begin
            n_tot.acc = sat_add(r_tot.acc, CNT_W'(1));
            n_tot.near_miss = sat_add(r_tot.near_miss, CNT_W'(i_upd.near_miss));
            n_tot.far_acc = sat_add(r_tot.far_acc, CNT_W'(i_upd.near_miss));
            n_tot.far_miss = sat_add(r_tot.far_miss, CNT_W'(i_upd.far_miss));
            n_tot.lat = sat_add(r_tot.lat, CNT_W'(i_upd.lat));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else begin
            r_tot <= n_tot;
        end
    end

    assign o_tot = r_tot;

endmodule

// ----- hdl/two_level_inclusive_cache_controller.sv -----
// Two-level inclusive write-back cache tag controller with true LRU. One access is
// taken at a time and walks the tag row memories of each level (one read and one
// write port each; one row read and one row write per cycle): read, lookup, then a
// back-invalidate and first level reread if a valid second level line is evicted,
// first level fill on allocation (write-back of a dirty victim), then done. After
// reset a clearing pass over max(first level sets, second level sets) rows (256 at
// the defaults) runs before any access; configuration writes are taken at any time.
module two_level_inclusive_cache_controller #(
    parameter int BLOCK_BITS    = 4,
    parameter int NEAR_SET_BITS = 6,
    parameter int NEAR_WAYS     = 2,
    parameter int FAR_SET_BITS  = 8,
    parameter int FAR_WAYS      = 4,
    parameter int ADDR_BITS     = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [31:0]                      i_address,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_first_hit,
    output logic                             o_second_hit,
    output logic [tcc_pkg::LAT_W-1:0]        o_access_latency,
    output logic [tcc_pkg::CNT_W-1:0]        o_access_total,
    output logic [tcc_pkg::CNT_W-1:0]        o_first_miss_total,
    output logic [tcc_pkg::CNT_W-1:0]        o_second_access_total,
    output logic [tcc_pkg::CNT_W-1:0]        o_second_miss_total,
    output logic [tcc_pkg::CNT_W-1:0]        o_latency_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tcc_pkg::*;

    localparam int BW        = ADDR_BITS - BLOCK_BITS;
    localparam int NTW       = BW - NEAR_SET_BITS;
    localparam int FTW       = BW - FAR_SET_BITS;
    localparam int NEAR_SETS = 1 << NEAR_SET_BITS;
    localparam int FAR_SETS  = 1 << FAR_SET_BITS;
    localparam int NIW       = (NEAR_SET_BITS > 0) ? NEAR_SET_BITS : 1;
    localparam int FIW       = (FAR_SET_BITS > 0) ? FAR_SET_BITS : 1;
    localparam int NAW       = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
    localparam int FAW       = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;
    localparam int CLR_SETS  = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
    localparam int CW        = $clog2(CLR_SETS) + 1;

    typedef struct packed {
        logic [NEAR_WAYS-1:0][NTW-1:0] tag;
        logic [NEAR_WAYS-1:0]          vld;
        logic [NEAR_WAYS-1:0]          dty;
        logic [NEAR_WAYS-1:0][NAW-1:0] age;
    } t_nrow;

    typedef struct packed {
        logic [FAR_WAYS-1:0][FTW-1:0] tag;
        logic [FAR_WAYS-1:0]          vld;
        logic [FAR_WAYS-1:0]          dty;
        logic [FAR_WAYS-1:0][FAW-1:0] age;
    } t_frow;

    t_nrow near_mem [NEAR_SETS];
    t_frow far_mem [FAR_SETS];

    function automatic logic [NAW:0] n_find(t_nrow r, logic [NTW-1:0] k);
        logic [NAW:0] f;
        f = '0;
        for (int i = NEAR_WAYS - 1; i >= 0; i--) begin
            if (r.vld[i] && r.tag[i] == k) f = {1'b1, NAW'(i)};
        end
        return f;
    endfunction

    function automatic logic [FAW:0] f_find(t_frow r, logic [FTW-1:0] k);
        logic [FAW:0] f;
        f = '0;
        for (int i = FAR_WAYS - 1; i >= 0; i--) begin
            if (r.vld[i] && r.tag[i] == k) f = {1'b1, FAW'(i)};
        end
        return f;
    endfunction

    function automatic t_nrow n_touch(t_nrow r, logic [NAW-1:0] w);
        t_nrow o;
        o = r;
        for (int i = 0; i < NEAR_WAYS; i++) begin
            if (r.age[i] < r.age[w]) o.age[i] = r.age[i] + 1'b1;
        end
        o.age[w] = '0;
        return o;
    endfunction

    function automatic t_frow f_touch(t_frow r, logic [FAW-1:0] w);
        t_frow o;
        o = r;
        for (int i = 0; i < FAR_WAYS; i++) begin
            if (r.age[i] < r.age[w]) o.age[i] = r.age[i] + 1'b1;
        end
        o.age[w] = '0;
        return o;
    endfunction

    function automatic logic [NAW-1:0] n_victim(t_nrow r);
        logic [NAW-1:0] v;
        v = '0;
        for (int i = 0; i < NEAR_WAYS; i++) begin
            if (r.age[i] == NAW'(NEAR_WAYS - 1)) v = NAW'(i);
        end
        for (int i = NEAR_WAYS - 1; i >= 0; i--) begin
            if (!r.vld[i]) v = NAW'(i);
        end
        return v;
    endfunction

    function automatic logic [FAW-1:0] f_victim(t_frow r);
        logic [FAW-1:0] v;
        v = '0;
        for (int i = 0; i < FAR_WAYS; i++) begin
            if (r.age[i] == FAW'(FAR_WAYS - 1)) v = FAW'(i);
        end
        for (int i = FAR_WAYS - 1; i >= 0; i--) begin
            if (!r.vld[i]) v = FAW'(i);
        end
        return v;
    endfunction

    function automatic t_nrow n_clear();
        t_nrow o;
        o = '0;
        for (int i = 0; i < NEAR_WAYS; i++) o.age[i] = NAW'(i);
        return o;
    endfunction

    function automatic t_frow f_clear();
        t_frow o;
        o = '0;
        for (int i = 0; i < FAR_WAYS; i++) o.age[i] = FAW'(i);
        return o;
    endfunction

    t_state                r_state, n_state;
    logic [CW-1:0]         r_clr, n_clr;
    logic                  r_mode, n_mode;
    logic [BW-1:0]         r_blk, n_blk;
    logic                  r_walloc;
    logic [CFG_DATA_W-1:0] r_lat1, r_lat2, r_latm;
    t_nrow                 r_nrd;
    t_frow                 r_frd;
    logic [NIW-1:0]        r_kn_set, n_kn_set;
    logic [NTW-1:0]        r_kn_tag, n_kn_tag;
    logic [FIW-1:0]        r_kf_set, n_kf_set;
    logic [FTW-1:0]        r_kf_tag, n_kf_tag;
    logic                  r_h1, n_h1, r_h2, n_h2;
    logic [LAT_W-1:0]      r_lat, n_lat;
    logic                  r_ovld, n_ovld;
    logic                  r_o_h1, n_o_h1, r_o_h2, n_o_h2;
    logic [LAT_W-1:0]      r_o_lat, n_o_lat;
    t_totals               r_o_tot, n_o_tot;

    logic                  nre, nwe, fre, fwe;
    logic [NIW-1:0]        nra, nwa;
    logic [FIW-1:0]        fra, fwa;
    t_nrow                 nwd;
    t_frow                 fwd;
    t_stat_upd             upd;
    t_totals               tot;

    logic [NIW-1:0]        ns;
    logic [FIW-1:0]        fs;
    logic [NTW-1:0]        nt;
    logic [FTW-1:0]        ft;
    logic                  alloc;
    logic [NAW:0]          nf;
    logic [FAW:0]          ff;
    logic [NAW-1:0]        nv;
    logic [FAW-1:0]        fv;
    logic [BW-1:0]         eblk, vblk;
    logic [LAT_W-1:0]      lat;

    assign ns    = NIW'(r_blk & BW'(NEAR_SETS - 1));
    assign fs    = FIW'(r_blk & BW'(FAR_SETS - 1));
    assign nt    = NTW'(r_blk >> NEAR_SET_BITS);
    assign ft    = FTW'(r_blk >> FAR_SET_BITS);
    assign alloc = !r_mode || r_walloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_mode   = r_mode;
        n_blk    = r_blk;
        n_kn_set = r_kn_set;
        n_kn_tag = r_kn_tag;
        n_kf_set = r_kf_set;
        n_kf_tag = r_kf_tag;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_lat    = r_lat;
        n_ovld   = r_ovld && i_stall;
        n_o_h1   = r_o_h1;
        n_o_h2   = r_o_h2;
        n_o_lat  = r_o_lat;
        n_o_tot  = r_o_tot;
        nre = 1'b0;
        nra = ns;
        nwe = 1'b0;
        nwa = ns;
        nwd = r_nrd;
        fre = 1'b0;
        fra = fs;
        fwe = 1'b0;
        fwa = fs;
        fwd = r_frd;
        upd = '0;
        nf  = n_find(r_nrd, nt);
        ff  = f_find(r_frd, ft);
        nv  = n_victim(r_nrd);
        fv  = f_victim(r_frd);
        eblk = (BW'(r_frd.tag[fv]) << FAR_SET_BITS) | BW'(fs);
        vblk = (BW'(r_nrd.tag[nv]) << NEAR_SET_BITS) | BW'(ns);
        lat = LAT_W'(r_lat1);
        if (!nf[NAW]) begin
            lat = lat + LAT_W'(r_lat2);
            if (!ff[FAW]) lat = lat + LAT_W'(r_latm);
        end
        case (r_state)
            S_CLEAR: begin
                nwe = (r_clr < CW'(NEAR_SETS));
                nwa = NIW'(r_clr);
                nwd = n_clear();
                fwe = (r_clr < CW'(FAR_SETS));
                fwa = FIW'(r_clr);
                fwd = f_clear();
                n_clr = r_clr + 1'b1;
                if (r_clr == CW'(CLR_SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_blk   = BW'(ADDR_BITS'(i_address) >> BLOCK_BITS);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                nre = 1'b1;
                fre = 1'b1;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                upd.valid     = 1'b1;
                upd.near_miss = !nf[NAW];
                upd.far_miss  = !nf[NAW] && !ff[FAW];
                upd.lat       = lat;
                n_lat = lat;
                n_h1  = nf[NAW];
                n_h2  = !nf[NAW] && ff[FAW];
                n_state = S_DONE;
                if (nf[NAW]) begin
                    nwd = n_touch(r_nrd, nf[NAW-1:0]);
                    if (r_mode) nwd.dty[nf[NAW-1:0]] = 1'b1;
                    nwe = 1'b1;
                end else if (ff[FAW]) begin
                    fwd = f_touch(r_frd, ff[FAW-1:0]);
                    if (r_mode) fwd.dty[ff[FAW-1:0]] = !r_walloc;
                    fwe = 1'b1;
                    if (alloc) n_state = S_NFILL;
                end else if (alloc) begin
                    fwd = r_frd;
                    fwd.tag[fv] = ft;
                    fwd.vld[fv] = 1'b1;
                    fwd.dty[fv] = 1'b0;
                    fwd = f_touch(fwd, fv);
                    fwe = 1'b1;
                    n_state = S_NFILL;
                    if (r_frd.vld[fv]) begin
                        nre = 1'b1;
                        nra = NIW'(eblk & BW'(NEAR_SETS - 1));
                        n_kn_set = NIW'(eblk & BW'(NEAR_SETS - 1));
                        n_kn_tag = NTW'(eblk >> NEAR_SET_BITS);
                        n_state = S_BINV;
                    end
                end
            end
            S_BINV: begin
                nf = n_find(r_nrd, r_kn_tag);
                if (nf[NAW]) begin
                    nwd = r_nrd;
                    nwd.vld[nf[NAW-1:0]] = 1'b0;
                    nwd.dty[nf[NAW-1:0]] = 1'b0;
                    nwa = r_kn_set;
                    nwe = 1'b1;
                end
                n_state = S_NRD;
            end
            S_NRD: begin
                nre = 1'b1;
                n_state = S_NFILL;
            end
            S_NFILL: begin
                nwd = r_nrd;
                nwd.tag[nv] = nt;
                nwd.vld[nv] = 1'b1;
                nwd.dty[nv] = r_mode;
                nwd = n_touch(nwd, nv);
                nwe = 1'b1;
                n_state = S_DONE;
                if (r_nrd.vld[nv] && r_nrd.dty[nv]) begin
                    fre = 1'b1;
                    fra = FIW'(vblk & BW'(FAR_SETS - 1));
                    n_kf_set = FIW'(vblk & BW'(FAR_SETS - 1));
                    n_kf_tag = FTW'(vblk >> FAR_SET_BITS);
                    n_state = S_WB;
                end
            end
            S_WB: begin
                ff = f_find(r_frd, r_kf_tag);
                if (ff[FAW]) begin
                    fwd = r_frd;
                    fwd.dty[ff[FAW-1:0]] = 1'b1;
                    fwd = f_touch(fwd, ff[FAW-1:0]);
                    fwa = r_kf_set;
                    fwe = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || !i_stall) begin
                    n_ovld  = 1'b1;
                    n_o_h1  = r_h1;
                    n_o_h2  = r_h2;
                    n_o_lat = r_lat;
                    n_o_tot = tot;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nwe) near_mem[nwa] <= nwd;
        if (nre) r_nrd <= near_mem[nra];
    end

    always_ff @(posedge i_clk) begin
        if (fwe) far_mem[fwa] <= fwd;
        if (fre) r_frd <= far_mem[fra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovld   <= 1'b0;
            r_walloc <= 1'b1;
            r_lat1   <= CFG_DATA_W'(1);
            r_lat2   <= CFG_DATA_W'(5);
            r_latm   <= CFG_DATA_W'(100);
        end else begin
            r_clr  <= n_clr;
            r_ovld <= n_ovld;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WRITE_ALLOC: r_walloc <= i_cfg_data[0];
                    CFG_NEAR_LAT:    r_lat1 <= i_cfg_data;
                    CFG_FAR_LAT:     r_lat2 <= i_cfg_data;
                    CFG_MEM_LAT:     r_latm <= i_cfg_data;
                    default:         r_latm <= r_latm;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_blk    <= n_blk;
        r_kn_set <= n_kn_set;
        r_kn_tag <= n_kn_tag;
        r_kf_set <= n_kf_set;
        r_kf_tag <= n_kf_tag;
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_lat    <= n_lat;
        r_o_h1   <= n_o_h1;
        r_o_h2   <= n_o_h2;
        r_o_lat  <= n_o_lat;
        r_o_tot  <= n_o_tot;
    end

    tcc_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_tot   (tot)
    );

    assign o_stall               = (r_state != S_IDLE);
    assign o_cfg_ready           = 1'b1;
    assign o_valid               = r_ovld;
    assign o_first_hit           = r_o_h1;
    assign o_second_hit          = r_o_h2;
    assign o_access_latency      = r_o_lat;
    assign o_access_total        = r_o_tot.acc;
    assign o_first_miss_total    = r_o_tot.near_miss;
    assign o_second_access_total = r_o_tot.far_acc;
    assign o_second_miss_total   = r_o_tot.far_miss;
    assign o_latency_total       = r_o_tot.lat;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_first_hit && o_second_hit))
        else $error("both hit flags set");

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nwe |-> &(~nwd.dty | nwd.vld))
        else $error("near line dirty but not valid");

    a_wb_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |=> r_state == S_DONE)
        else $error("write-back step did not finish access");

endmodule
